/* rtl/core/nmoe_pkg.sv */
// ----------------------------------------------------------------------------
// nmoe_pkg
// Shared widths, constants, state and command types for the n-th multiple
// search block.
// ----------------------------------------------------------------------------
package nmoe_pkg;

    localparam int RANK_BITS    = 30;
    localparam int DIVISOR_BITS = 16;
    localparam int VALUE_BITS   = 30;

    // Search range n*min(a,b) and all quotients live in SEARCH_BITS.
    localparam int SEARCH_BITS  = RANK_BITS + DIVISOR_BITS;
    localparam int LCM_BITS     = 2 * DIVISOR_BITS;
    localparam int MOD_BITS     = 30;
    localparam int DIVR_BITS    = (LCM_BITS > MOD_BITS) ? LCM_BITS : MOD_BITS;
    localparam int CNT_BITS     = $clog2(SEARCH_BITS);

    localparam logic [MOD_BITS-1:0] RESULT_MODULUS = MOD_BITS'(1000000007);
    // 2^MOD_BITS mod RESULT_MODULUS; folds the bits above MOD_BITS back down.
    localparam logic [MOD_BITS-1:0] MOD_FOLD =
        MOD_BITS'((64'd1 << MOD_BITS) - 64'd1000000007);

    typedef enum logic [1:0] {
        DIV_GCD,
        DIV_LCM,
        DIV_SEARCH
    } div_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD_TEST,
        S_GCD_WAIT,
        S_LCM_WAIT,
        S_SEARCH,
        S_DIV_WAIT,
        S_MOD_WAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    load;
        logic    div_start;
        div_op_t div_op;
        logic    gcd_step;
        logic    search_init;
        logic    decide;
        logic    mod_init;
        logic    mod_step;
        logic    result_load;
    } cmd_t;

    typedef struct packed {
        logic invalid;
        logic gcd_y_zero;
        logic div_done;
        logic search_done;
        logic mod_done;
    } status_t;

endpackage

/* rtl/core/nmoe_divider.sv */
// ----------------------------------------------------------------------------
// nmoe_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nmoe_divider (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [nmoe_pkg::SEARCH_BITS-1:0] dividend,
    input  logic [nmoe_pkg::DIVR_BITS-1:0]   divisor,
    output logic                             done,
    output logic [nmoe_pkg::SEARCH_BITS-1:0] quotient,
    output logic [nmoe_pkg::DIVR_BITS-1:0]   remainder
);
    import nmoe_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [SEARCH_BITS-1:0] quo_reg, quo_next;
    logic [DIVR_BITS-1:0]   rem_reg, rem_next;
    logic [DIVR_BITS-1:0]   dvs_reg, dvs_next;
    logic [DIVR_BITS:0]     rem_shift;
    logic [DIVR_BITS:0]     rem_diff;

    assign rem_shift = {rem_reg, quo_reg[SEARCH_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(SEARCH_BITS - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in next dividend bit, subtract when it fits
            if (rem_shift >= {1'b0, dvs_reg})
            begin
                rem_next = rem_diff[DIVR_BITS-1:0];
                quo_next = {quo_reg[SEARCH_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DIVR_BITS-1:0];
                quo_next = {quo_reg[SEARCH_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider not busy after start");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && cnt_reg == '0) |=> done_reg)
        else $error("divider missed done after last step");

endmodule

/* rtl/core/nmoe_datapath.sv */
// ----------------------------------------------------------------------------
// nmoe_datapath
// Operand registers, gcd/lcm, search bounds, three dividers and result.
// ----------------------------------------------------------------------------
module nmoe_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  nmoe_pkg::cmd_t                    cmd,
    output nmoe_pkg::status_t                 status,
    input  logic [nmoe_pkg::RANK_BITS-1:0]    rank,
    input  logic [nmoe_pkg::DIVISOR_BITS-1:0] divisor_a,
    input  logic [nmoe_pkg::DIVISOR_BITS-1:0] divisor_b,
    output logic [nmoe_pkg::VALUE_BITS-1:0]   value_mod,
    output logic                              invalid
);
    import nmoe_pkg::*;

    logic [RANK_BITS-1:0]    n_reg;
    logic [DIVISOR_BITS-1:0] a_reg, b_reg;
    logic                    inv_reg;
    logic [DIVISOR_BITS-1:0] gx_reg, gy_reg;
    logic [LCM_BITS-1:0]     lcm_reg;
    logic [SEARCH_BITS-1:0]  lo_reg, hi_reg;
    logic [SEARCH_BITS-1:0]  mod_reg;
    logic [VALUE_BITS-1:0]   value_reg;
    logic                    invalid_reg;

    logic [SEARCH_BITS:0]    mid_sum;
    logic [SEARCH_BITS-1:0]  mid;
    logic [DIVISOR_BITS-1:0] min_ab;
    logic [SEARCH_BITS+1:0]  count;
    logic [SEARCH_BITS-1:0]  fold_prod;
    logic [SEARCH_BITS-1:0]  fold_sum;
    logic [MOD_BITS-1:0]     mod_low;
    logic [MOD_BITS-1:0]     mod_final;

    logic [SEARCH_BITS-1:0]  div_dividend [3];
    logic [DIVR_BITS-1:0]    div_divisor  [3];
    logic                    div_done     [3];
    logic [SEARCH_BITS-1:0]  div_quo      [3];
    logic [DIVR_BITS-1:0]    div_rem      [3];

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[SEARCH_BITS:1];
    assign min_ab  = (a_reg < b_reg) ? a_reg : b_reg;
    assign count   = {2'b00, div_quo[0]} + {2'b00, div_quo[1]} - {2'b00, div_quo[2]};

    // fold the bits above MOD_BITS back with 2^MOD_BITS mod modulus
    assign fold_prod = mod_reg[SEARCH_BITS-1:MOD_BITS] * MOD_FOLD;
    assign fold_sum  = fold_prod + SEARCH_BITS'(mod_reg[MOD_BITS-1:0]);
    assign mod_low   = mod_reg[MOD_BITS-1:0];
    assign mod_final = (mod_low >= RESULT_MODULUS) ? mod_low - RESULT_MODULUS : mod_low;

    // operand select; dividers capture operands on start
    always_comb
    begin
        div_dividend[0] = mid;
        div_divisor[0]  = DIVR_BITS'(a_reg);
        div_dividend[1] = mid;
        div_divisor[1]  = DIVR_BITS'(b_reg);
        div_dividend[2] = mid;
        div_divisor[2]  = DIVR_BITS'(lcm_reg);
        case (cmd.div_op)
            DIV_GCD:
            begin
                div_dividend[0] = SEARCH_BITS'(gx_reg);
                div_divisor[0]  = DIVR_BITS'(gy_reg);
            end
            DIV_LCM:
            begin
                div_dividend[0] = SEARCH_BITS'(a_reg);
                div_divisor[0]  = DIVR_BITS'(gx_reg);
            end
            default:
            begin
                div_dividend[0] = mid;
            end
        endcase
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        nmoe_divider u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .start     (cmd.div_start && (i == 0 || cmd.div_op == DIV_SEARCH)),
            .dividend  (div_dividend[i]),
            .divisor   (div_divisor[i]),
            .done      (div_done[i]),
            .quotient  (div_quo[i]),
            .remainder (div_rem[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg   <= rank;
            a_reg   <= divisor_a;
            b_reg   <= divisor_b;
            gx_reg  <= divisor_a;
            gy_reg  <= divisor_b;
            inv_reg <= (rank == '0) || (divisor_a == '0) || (divisor_b == '0);
        end
        if (cmd.gcd_step)
        begin
            gx_reg <= gy_reg;
            gy_reg <= div_rem[0][DIVISOR_BITS-1:0];
        end
        if (cmd.search_init)
        begin
            lcm_reg <= div_quo[0][DIVISOR_BITS-1:0] * b_reg;
            lo_reg  <= SEARCH_BITS'(1);
            hi_reg  <= n_reg * min_ab;
        end
        if (cmd.decide)
        begin
            if (count >= {2'b00, SEARCH_BITS'(n_reg)})
                hi_reg <= mid;
            else
                lo_reg <= mid + 1'b1;
        end
        if (cmd.mod_init)
            mod_reg <= lo_reg;
        else if (cmd.mod_step)
            mod_reg <= fold_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg   <= '0;
            invalid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            value_reg   <= inv_reg ? '0 : mod_final;
            invalid_reg <= inv_reg;
        end
    end

    assign status.invalid     = inv_reg;
    assign status.gcd_y_zero  = (gy_reg == '0);
    assign status.div_done    = div_done[0];
    assign status.search_done = (lo_reg == hi_reg);
    assign status.mod_done    = (mod_reg[SEARCH_BITS-1:MOD_BITS] == '0);

    assign value_mod = value_reg;
    assign invalid   = invalid_reg;

endmodule

/* rtl/core/nmoe_control.sv */
// ----------------------------------------------------------------------------
// nmoe_control
// Sequencer for gcd, lcm, binary search and final reduction.
// ----------------------------------------------------------------------------
module nmoe_control (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output nmoe_pkg::cmd_t    cmd,
    input  nmoe_pkg::status_t status
);
    import nmoe_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.div_op     = DIV_SEARCH;
        in_stall       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_GCD_TEST;
                end
            end
            S_GCD_TEST:
            begin
                if (status.invalid)
                    state_next = S_FINISH;
                else if (status.gcd_y_zero)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_LCM;
                    state_next    = S_LCM_WAIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_GCD;
                    state_next    = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.gcd_step = 1'b1;
                    state_next   = S_GCD_TEST;
                end
            end
            S_LCM_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.search_init = 1'b1;
                    state_next      = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (status.search_done)
                begin
                    cmd.mod_init = 1'b1;
                    state_next   = S_MOD_WAIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.decide = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_MOD_WAIT:
            begin
                // fold until the value fits in the modulus width
                if (status.mod_done)
                    state_next = S_FINISH;
                else
                    cmd.mod_step = 1'b1;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.result_load = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/nth_multiple_of_either.sv */
// Timing: from input transfer to output valid, one divider pass per Euclid
//   step E, one for the lcm and one per search step S, then F modulo fold
//   steps; E is up to 23 for 16-bit divisors, S up to 46, F up to 8.
// Throughput: one item at a time; the next transfer is taken back in idle.
//   Zero rank or divisor skips to the result. A stalled result adds its wait.
// Reset: rst_n asynchronous, active low; clears controller and output valid.
// ----------------------------------------------------------------------------
// nth_multiple_of_either
// Returns the n-th positive integer divisible by a or b, modulo 1000000007.
// ----------------------------------------------------------------------------
module nth_multiple_of_either (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [nmoe_pkg::RANK_BITS-1:0]    rank,
    input  logic [nmoe_pkg::DIVISOR_BITS-1:0] divisor_a,
    input  logic [nmoe_pkg::DIVISOR_BITS-1:0] divisor_b,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [nmoe_pkg::VALUE_BITS-1:0]   value_mod,
    output logic                              invalid
);
    import nmoe_pkg::*;

    // Flow: take a transfer in idle, run Euclid on the shared divider to
    // get gcd, divide a by gcd and multiply by b for the lcm, then bisect
    // [1, n*min(a,b)] with three dividers counting multiples in parallel.
    // Reduce the final low bound modulo 1000000007 by folding the bits
    // above 30 back with 2^30 mod 1000000007, one fold per cycle, then one
    // conditional subtract.
    // The result register frees the controller to take the next transfer
    // while a finished result still waits downstream.

    cmd_t    cmd;
    status_t status;

    nmoe_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    nmoe_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .rank      (rank),
        .divisor_a (divisor_a),
        .divisor_b (divisor_b),
        .value_mod (value_mod),
        .invalid   (invalid)
    );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: n-th multiple of either divisor
// Drives rank/divisor transfers with random gaps and stalls, predicts each
// result with a software binary search, and checks every output transfer.
// ----------------------------------------------------------------------------

// Holds expected results in arrival order and checks each output transfer.
class multiple_scoreboard;
    logic [29:0] value_q[$];
    logic        flag_q[$];
    int          mismatches;

    function longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned r;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Compute the n-th multiple of a or b, reduced modulo 1e9+7.
    function void note_transfer(logic [29:0] n, logic [15:0] a, logic [15:0] b);
        longint unsigned g, lcm, lo, hi, mid, best, cnt;
        if (n == 0 || a == 0 || b == 0)
        begin
            value_q.push_back('0);
            flag_q.push_back(1'b1);
            return;
        end
        g   = gcd_of(a, b);
        lcm = (64'(a) / g) * b;
        lo  = 1;
        hi  = 64'(n) * ((a < b) ? a : b);
        best = hi;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            cnt = mid / a + mid / b - mid / lcm;
            if (cnt >= n)
            begin
                best = mid;
                hi   = mid - 1;
            end
            else
                lo = mid + 1;
        end
        value_q.push_back(30'(best % 64'd1000000007));
        flag_q.push_back(1'b0);
    endfunction

    function void check_result(logic [29:0] value, logic flag);
        logic [29:0] ev;
        logic        ef;
        if (value_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: value=%0d invalid=%0b", value, flag);
            return;
        end
        ev = value_q.pop_front();
        ef = flag_q.pop_front();
        if (value !== ev || flag !== ef)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected value=%0d invalid=%0b, got value=%0d invalid=%0b",
                         ev, ef, value, flag);
        end
    endfunction

    function int pending();
        return value_q.size();
    endfunction
endclass

module testbench;
    import nmoe_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [RANK_BITS-1:0]    rank;
    logic [DIVISOR_BITS-1:0] divisor_a;
    logic [DIVISOR_BITS-1:0] divisor_b;
    logic                    out_valid;
    logic                    out_stall;
    logic [VALUE_BITS-1:0]   value_mod;
    logic                    invalid;

    multiple_scoreboard sb;
    bit                 stimulus_done;

    nth_multiple_of_either dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rank      (rank),
        .divisor_a (divisor_a),
        .divisor_b (divisor_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value_mod (value_mod),
        .invalid   (invalid)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Pick a random gap; about one draw in four is forced to zero, back to back.
    function automatic int draw_gap();
        if ($urandom_range(3) == 0)
            return 0;
        return int'($urandom_range(18));
    endfunction

    // Present one transfer after a random gap and hold it until accepted.
    task automatic send_item(logic [29:0] n, logic [15:0] a, logic [15:0] b);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        rank      <= n;
        divisor_a <= a;
        divisor_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_transfer(n, a, b);
    endtask

    // Mostly small ranks and divisors so each search stays short.
    task automatic send_random();
        logic [29:0] n;
        logic [15:0] a, b;
        case ($urandom_range(9))
            0: n = 30'($urandom());
            1, 2: n = 30'($urandom_range(1 << 20));
            default: n = 30'($urandom_range(1000));
        endcase
        case ($urandom_range(9))
            0, 1: a = 16'($urandom());
            2: a = 16'hFFFF - 16'($urandom_range(3));
            default: a = 16'($urandom_range(300));
        endcase
        case ($urandom_range(9))
            0, 1: b = 16'($urandom());
            2: b = a;
            default: b = 16'($urandom_range(300));
        endcase
        // Keep zero inputs rare; $urandom_range(300) already reaches zero.
        if ($urandom_range(15) != 0)
        begin
            if (a == 0) a = 1;
            if (b == 0) b = 7;
            if (n == 0) n = 3;
        end
        send_item(n, a, b);
    endtask

    // Random stall on the result side, drawn per result.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = draw_gap();
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Compare every output transfer.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(value_mod, invalid);
    end

    initial
    begin
        sb            = new();
        stimulus_done = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rank          = '0;
        divisor_a     = '0;
        divisor_b     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: invalid cases, extremes, equal and coprime divisors.
        send_item(30'd0, 16'd5, 16'd7);
        send_item(30'd4, 16'd0, 16'd7);
        send_item(30'd4, 16'd5, 16'd0);
        send_item(30'd0, 16'd0, 16'd0);
        send_item(30'd1, 16'd1, 16'd1);
        send_item(30'd1, 16'd2, 16'd3);
        send_item(30'd5, 16'd2, 16'd4);
        send_item(30'd3, 16'd6, 16'd4);
        send_item(30'd100, 16'd7, 16'd7);
        send_item(30'h3FFFFFFF, 16'd1, 16'd1);
        send_item(30'h3FFFFFFF, 16'hFFFF, 16'hFFFF);
        send_item(30'h3FFFFFFF, 16'hFFFF, 16'hFFFE);
        send_item(30'h2AAAAAAA, 16'h5555, 16'hAAAA);
        send_item(30'h15555555, 16'hAAAA, 16'h5555);
        send_item(30'd1, 16'hFFFF, 16'd1);
        send_item(30'd1000000, 16'd40000, 16'd40000 - 16'd1);
        send_item(30'd1000000007, 16'd1, 16'd2);
        send_item(30'd12345, 16'd8191, 16'd131);

        repeat (200) send_random();
        @(negedge clk);
        in_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial
    begin
        wait (stimulus_done);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: covers ~220 items plus stalls, taken many times over.
    initial
    begin
        #100ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
